/* rtl/truss_stiffness_assembly_defines.svh */
// Assertion macros shared by the truss stiffness assembly RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef TRUSS_STIFFNESS_ASSEMBLY_DEFINES_SVH
`define TRUSS_STIFFNESS_ASSEMBLY_DEFINES_SVH

// same-cycle implication
`define TSA_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tsa assertion failed");

// next-cycle implication
`define TSA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tsa assertion failed");

`endif

/* rtl/tsa_pkg.sv */
// Shared types and constants for the truss stiffness assembly block.
// Used by tsa_ctrl, tsa_datapath and the top level; depends on nothing.
`default_nettype none

package tsa_pkg;

    localparam int DOF_PER_NODE = 2;
    localparam int ENTRY_W      = 48;
    localparam int Q_W          = 32;   // quotient bits, |v| <= k*256 < 2^32
    localparam int V_W          = 33;   // signed term width
    localparam int D_W          = 33;   // squared length width

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_LEN = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    localparam logic [3:0] OP_NONE   = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_DIFF   = 4'd2;
    localparam logic [3:0] OP_PROD   = 4'd3;
    localparam logic [3:0] OP_DSUM   = 4'd4;
    localparam logic [3:0] OP_MUL    = 4'd5;
    localparam logic [3:0] OP_DIV    = 4'd6;
    localparam logic [3:0] OP_STORE  = 4'd7;
    localparam logic [3:0] OP_WR     = 4'd8;
    localparam logic [3:0] OP_CLR    = 4'd9;
    localparam logic [3:0] OP_RESULT = 4'd10;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         start_node;
        logic [5:0]         end_node;
        logic signed [15:0] start_x;
        logic signed [15:0] start_y;
        logic signed [15:0] end_x;
        logic signed [15:0] end_y;
        logic [23:0]        spring_stiffness;
        logic               rigid_flag;
        logic [6:0]         read_row;
        logic [6:0]         read_col;
    } tsa_req_t;

    typedef struct packed {
        logic signed [47:0] entry_value;
        logic [1:0]         status;
    } tsa_rsp_t;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] term;   // 0: xx, 1: yy, 2: xy
        logic [3:0] idx;    // element entry {bi, bj, i, j}
    } tsa_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       zero_len;
        logic       nodes_ok;
        logic       clr_last;
    } tsa_stat_t;

endpackage

`default_nettype wire

/* rtl/tsa_ctrl.sv */
// Sequencer for the truss stiffness assembly block.
// Depends on tsa_pkg; drives tsa_datapath through tsa_cmd_t.
`default_nettype none

module tsa_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic              out_free,
    input  wire tsa_pkg::tsa_stat_t st,
    output tsa_pkg::tsa_cmd_t      cmd,
    output logic                   idle
);

    localparam logic [3:0] S_INIT_CLR = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DISPATCH = 4'd2;
    localparam logic [3:0] S_DIFF     = 4'd3;
    localparam logic [3:0] S_PROD     = 4'd4;
    localparam logic [3:0] S_DSUM     = 4'd5;
    localparam logic [3:0] S_CHECK    = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_DIV      = 4'd8;
    localparam logic [3:0] S_STORE    = 4'd9;
    localparam logic [3:0] S_RMW_RD   = 4'd10;
    localparam logic [3:0] S_RMW_WR   = 4'd11;
    localparam logic [3:0] S_CLR      = 4'd12;
    localparam logic [3:0] S_FIN      = 4'd13;

    logic [3:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [1:0] term_reg, term_next;
    logic [3:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT_CLR;
            cnt_reg   <= '0;
            term_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            term_reg  <= term_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        term_next  = term_reg;
        idx_next   = idx_reg;
        cmd.op     = tsa_pkg::OP_NONE;
        cmd.term   = term_reg;
        cmd.idx    = idx_reg;
        idle       = 1'b0;
        case (state_reg)
            S_INIT_CLR:
            begin
                cmd.op = tsa_pkg::OP_CLR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                idle = 1'b1;
                if (go)
                begin
                    cmd.op     = tsa_pkg::OP_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                // read request: memory read is issued this cycle
                case (st.req_type)
                    tsa_pkg::REQ_ADD:   state_next = S_DIFF;
                    tsa_pkg::REQ_CLEAR: state_next = S_CLR;
                    default:            state_next = S_FIN;
                endcase
            end
            S_DIFF:
            begin
                cmd.op     = tsa_pkg::OP_DIFF;
                state_next = S_PROD;
            end
            S_PROD:
            begin
                cmd.op     = tsa_pkg::OP_PROD;
                state_next = S_DSUM;
            end
            S_DSUM:
            begin
                cmd.op     = tsa_pkg::OP_DSUM;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                term_next = '0;
                if (st.zero_len || !st.nodes_ok)
                    state_next = S_FIN;
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op     = tsa_pkg::OP_MUL;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = tsa_pkg::OP_DIV;
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    state_next = S_STORE;
            end
            S_STORE:
            begin
                cmd.op = tsa_pkg::OP_STORE;
                if (term_reg == 2'd2)
                begin
                    idx_next   = '0;
                    state_next = S_RMW_RD;
                end
                else
                begin
                    term_next  = term_reg + 2'd1;
                    state_next = S_MUL;
                end
            end
            S_RMW_RD:
            begin
                state_next = S_RMW_WR;
            end
            S_RMW_WR:
            begin
                cmd.op   = tsa_pkg::OP_WR;
                idx_next = idx_reg + 4'd1;
                if (idx_reg == 4'd15)
                    state_next = S_FIN;
                else
                    state_next = S_RMW_RD;
            end
            S_CLR:
            begin
                cmd.op = tsa_pkg::OP_CLR;
                if (st.clr_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.op     = tsa_pkg::OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/tsa_datapath.sv */
// Datapath: element terms, shared restoring divider, matrix memory with
// saturating read-modify-write. Depends on tsa_pkg; driven by tsa_ctrl.
`default_nettype none

module tsa_datapath #(
    parameter int MAX_NODES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tsa_pkg::tsa_cmd_t cmd,
    input  wire tsa_pkg::tsa_req_t req,
    output tsa_pkg::tsa_stat_t     st,
    output tsa_pkg::tsa_rsp_t      result
);

    localparam int DOF   = MAX_NODES * tsa_pkg::DOF_PER_NODE;
    localparam int DEPTH = DOF * DOF;
    localparam int RW    = $clog2(DOF);
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [48:0] SUM_MAX = 49'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [48:0] SUM_MIN = -49'sh0_8000_0000_0000;

    tsa_pkg::tsa_req_t r_reg;
    logic [15:0] mx_reg, my_reg;
    logic        xneg_reg, yneg_reg;
    logic [31:0] pxx_reg, pyy_reg, pxy_reg;
    logic [tsa_pkg::D_W-1:0] d_reg;
    logic [tsa_pkg::D_W-1:0] rem_reg;
    logic [tsa_pkg::Q_W-1:0] quo_reg;
    logic signed [tsa_pkg::V_W-1:0] v_reg [3];
    logic        sat_reg;
    logic [tsa_pkg::ENTRY_W-1:0] rdata_reg;
    logic [AW-1:0] clr_addr_reg;
    logic [tsa_pkg::ENTRY_W-1:0] mem [DEPTH];

    logic signed [16:0] dx, dy;
    logic [23:0] kk;
    logic [31:0] prod_sel;
    logic [55:0] num;
    logic [tsa_pkg::D_W:0] trial;
    logic        qbit;
    logic [5:0]  node_r, node_c;
    logic [RW-1:0] row, col, rrow, rcol;
    logic [AW-1:0] entry_addr, read_addr, raddr, waddr;
    logic signed [tsa_pkg::V_W-1:0] vsel, delta;
    logic signed [48:0] sum;
    logic [tsa_pkg::ENTRY_W-1:0] wdata;
    logic        ovf, we, is_read, read_ok;

    assign dx = {r_reg.end_x[15], r_reg.end_x} - {r_reg.start_x[15], r_reg.start_x};
    assign dy = {r_reg.start_y[15], r_reg.start_y} - {r_reg.end_y[15], r_reg.end_y};
    assign kk = r_reg.rigid_flag ? 24'd0 : r_reg.spring_stiffness;

    always_comb
    begin
        case (cmd.term)
            2'd0:    prod_sel = pxx_reg;
            2'd1:    prod_sel = pyy_reg;
            default: prod_sel = pxy_reg;
        endcase
    end

    // numerator is k*|a|*|b|*256; the top 32 bits start below d
    assign num   = 56'(kk) * 56'(prod_sel);
    assign trial = {rem_reg, quo_reg[tsa_pkg::Q_W-1]} - {1'b0, d_reg};
    assign qbit  = !trial[tsa_pkg::D_W];

    // element entry {bi, bj, i, j}
    assign node_r = cmd.idx[3] ? r_reg.end_node : r_reg.start_node;
    assign node_c = cmd.idx[2] ? r_reg.end_node : r_reg.start_node;
    assign row    = RW'({node_r, cmd.idx[1]});
    assign col    = RW'({node_c, cmd.idx[0]});
    assign entry_addr = AW'(row) * AW'(DOF) + AW'(col);
    assign rrow   = RW'(r_reg.read_row);
    assign rcol   = RW'(r_reg.read_col);
    assign read_addr  = AW'(rrow) * AW'(DOF) + AW'(rcol);

    always_comb
    begin
        if (cmd.idx[1] != cmd.idx[0])
            vsel = v_reg[2];
        else if (cmd.idx[1])
            vsel = v_reg[1];
        else
            vsel = v_reg[0];
    end

    assign delta = (cmd.idx[3] ^ cmd.idx[2]) ? -vsel : vsel;
    assign sum   = {rdata_reg[47], rdata_reg} + 49'(delta);
    assign ovf   = sum[48] != sum[47];

    always_comb
    begin
        if (sum > SUM_MAX)
            wdata = SUM_MAX[47:0];
        else if (sum < SUM_MIN)
            wdata = SUM_MIN[47:0];
        else
            wdata = sum[47:0];
    end

    assign is_read = r_reg.req_type == tsa_pkg::REQ_READ;
    assign raddr   = is_read ? read_addr : entry_addr;
    assign we      = (cmd.op == tsa_pkg::OP_WR) || (cmd.op == tsa_pkg::OP_CLR);
    assign waddr   = (cmd.op == tsa_pkg::OP_CLR) ? clr_addr_reg : entry_addr;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= (cmd.op == tsa_pkg::OP_CLR) ? '0 : wdata;
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.op == tsa_pkg::OP_CLR)
            clr_addr_reg <= (clr_addr_reg == AW'(DEPTH - 1)) ? '0 : clr_addr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tsa_pkg::OP_LOAD:
            begin
                r_reg   <= req;
                sat_reg <= 1'b0;
            end
            tsa_pkg::OP_DIFF:
            begin
                mx_reg   <= dx[16] ? 16'(-dx) : dx[15:0];
                my_reg   <= dy[16] ? 16'(-dy) : dy[15:0];
                xneg_reg <= dx[16];
                yneg_reg <= dy[16];
            end
            tsa_pkg::OP_PROD:
            begin
                pxx_reg <= 32'(mx_reg) * 32'(mx_reg);
                pyy_reg <= 32'(my_reg) * 32'(my_reg);
                pxy_reg <= 32'(mx_reg) * 32'(my_reg);
            end
            tsa_pkg::OP_DSUM:
            begin
                d_reg <= {1'b0, pxx_reg} + {1'b0, pyy_reg};
            end
            tsa_pkg::OP_MUL:
            begin
                rem_reg <= {1'b0, num[55:24]};
                quo_reg <= {num[23:0], 8'd0};
            end
            tsa_pkg::OP_DIV:
            begin
                rem_reg <= qbit ? trial[tsa_pkg::D_W-1:0]
                                : {rem_reg[tsa_pkg::D_W-2:0], quo_reg[tsa_pkg::Q_W-1]};
                quo_reg <= {quo_reg[tsa_pkg::Q_W-2:0], qbit};
            end
            tsa_pkg::OP_STORE:
            begin
                // only the xy term can be negative
                if (cmd.term == 2'd2 && (xneg_reg != yneg_reg))
                    v_reg[cmd.term] <= -$signed({1'b0, quo_reg});
                else
                    v_reg[cmd.term] <= $signed({1'b0, quo_reg});
            end
            tsa_pkg::OP_WR:
            begin
                if (ovf || sum > SUM_MAX || sum < SUM_MIN)
                    sat_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign read_ok = (int'(r_reg.read_row) < DOF) && (int'(r_reg.read_col) < DOF);

    assign st.req_type = r_reg.req_type;
    assign st.zero_len = d_reg == '0;
    assign st.nodes_ok = (int'(r_reg.start_node) < MAX_NODES)
                      && (int'(r_reg.end_node) < MAX_NODES);
    assign st.clr_last = clr_addr_reg == AW'(DEPTH - 1);

    always_comb
    begin
        result.entry_value = '0;
        result.status      = tsa_pkg::ST_OK;
        if (is_read && read_ok)
            result.entry_value = rdata_reg;
        if (r_reg.req_type == tsa_pkg::REQ_ADD)
        begin
            if (st.zero_len)
                result.status = tsa_pkg::ST_ZERO_LEN;
            else if (st.nodes_ok && sat_reg)
                result.status = tsa_pkg::ST_SAT;
        end
    end

endmodule

`default_nettype wire

/* rtl/truss_stiffness_assembly.sv */
// Global 2D truss stiffness matrix: one request at a time (add spring, read
// entry, clear). After reset, and for each clear request, a clearing pass
// writes every one of the MAX_NODES*MAX_NODES*4 entries (16384 at the
// default), one per cycle, with no request taken during the pass after
// reset. In an add spring, the single restoring divider needs 32 steps for
// each of the three terms, then 16 read-modify-writes go through the one
// matrix memory. Zero-length springs and out-of-range nodes skip the
// division and the matrix writes.
// Depends on tsa_pkg, tsa_ctrl, tsa_datapath and the defines header.
`default_nettype none
`include "truss_stiffness_assembly_defines.svh"

module truss_stiffness_assembly #(
    parameter int MAX_NODES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    input  wire tsa_pkg::tsa_req_t req,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output tsa_pkg::tsa_rsp_t      rsp
);

    tsa_pkg::tsa_cmd_t  cmd;
    tsa_pkg::tsa_stat_t st;
    tsa_pkg::tsa_rsp_t  result;
    tsa_pkg::tsa_rsp_t  rsp_reg;
    logic               rsp_valid_reg;
    logic               idle, go, out_free;

    assign req_stall = !idle;
    assign go        = req_valid && idle;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    tsa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .out_free (out_free),
        .st       (st),
        .cmd      (cmd),
        .idle     (idle)
    );

    tsa_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .req    (req),
        .st     (st),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.op == tsa_pkg::OP_RESULT)
            rsp_valid_reg <= 1'b1;
        else if (!rsp_stall)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == tsa_pkg::OP_RESULT)
            rsp_reg <= result;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `TSA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
    `TSA_ASSERT_NOW(a_status_no_value, rsp_valid && rsp.status != tsa_pkg::ST_OK,
                    rsp.entry_value == '0)
    `TSA_ASSERT_NOW(a_status_code, rsp_valid, rsp.status <= tsa_pkg::ST_SAT)
    `TSA_ASSERT_NOW(a_result_slot_free, cmd.op == tsa_pkg::OP_RESULT,
                    !rsp_valid_reg || !rsp_stall)

endmodule

`default_nettype wire

/* dv/truss_stiffness_assembly_tb.sv */
// Testbench for truss_stiffness_assembly: directed and random requests checked
// against a behavioral model of the stiffness matrix held in a scoreboard class.
// Depends on tsa_pkg and the truss_stiffness_assembly RTL.
`default_nettype none

module truss_stiffness_assembly_tb;

    localparam int NODES      = 64;
    localparam int NDOF       = NODES * tsa_pkg::DOF_PER_NODE;
    localparam longint E_MAX  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint E_MIN  = -E_MAX - 1;
    localparam int CYCLE_CAP  = 1500000;
    localparam int N_RANDOM   = 430;
    localparam int REQ_W      = $bits(tsa_pkg::tsa_req_t);
    localparam logic [1:0] REQ_UNUSED = 2'd3;   // request code with no action

    class stiffness_scoreboard;
        longint             matrix [NDOF*NDOF];
        tsa_pkg::tsa_rsp_t  expected_q [$];
        int                 mismatches;
        int                 n_add, n_read, n_clear, n_zero_len, n_sat, n_checked;

        function new();
            foreach (matrix[i]) matrix[i] = 0;
        endfunction

        function automatic longint spring_term(longint unsigned k, longint a, longint b,
                                               longint unsigned d);
            longint unsigned ma, mb, num;
            longint q;
            ma = (a < 0) ? -a : a;
            mb = (b < 0) ? -b : b;
            num = k * (ma * mb) * 64'd256;
            q = longint'(num / d);
            return ((a < 0) != (b < 0)) ? -q : q;
        endfunction

        function automatic bit add_entry(int r, int c, longint delta);
            longint s;
            s = matrix[r*NDOF + c] + delta;
            if (s > E_MAX) begin
                matrix[r*NDOF + c] = E_MAX;
                return 1;
            end
            if (s < E_MIN) begin
                matrix[r*NDOF + c] = E_MIN;
                return 1;
            end
            matrix[r*NDOF + c] = s;
            return 0;
        endfunction

        // apply one accepted request and queue the response it should give
        function void note_request(tsa_pkg::tsa_req_t q);
            tsa_pkg::tsa_rsp_t rsp;
            longint dx, dy, v1, v2, v3;
            longint unsigned d, k;
            longint el [4][4];
            int nodes [2];
            int rr, rc;
            bit sat;
            rsp = '0;
            rr = int'(q.read_row);
            rc = int'(q.read_col);
            case (q.req_type)
                tsa_pkg::REQ_CLEAR: begin
                    n_clear++;
                    foreach (matrix[i]) matrix[i] = 0;
                end
                tsa_pkg::REQ_READ: begin
                    n_read++;
                    if (rr < NDOF && rc < NDOF)
                        rsp.entry_value = matrix[rr*NDOF + rc][47:0];
                end
                tsa_pkg::REQ_ADD: begin
                    n_add++;
                    dx = longint'(q.end_x) - longint'(q.start_x);
                    dy = -(longint'(q.end_y) - longint'(q.start_y));
                    d = longint'(dx*dx) + longint'(dy*dy);
                    if (d == 0) begin
                        rsp.status = tsa_pkg::ST_ZERO_LEN;
                        n_zero_len++;
                    end else if (int'(q.start_node) < NODES && int'(q.end_node) < NODES) begin
                        k = q.rigid_flag ? 64'd0 : 64'(q.spring_stiffness);
                        v1 = spring_term(k, dx, dx, d);
                        v2 = spring_term(k, dy, dy, d);
                        v3 = spring_term(k, dx, dy, d);
                        el = '{'{ v1,  v3, -v1, -v3}, '{ v3,  v2, -v3, -v2},
                               '{-v1, -v3,  v1,  v3}, '{-v3, -v2,  v3,  v2}};
                        nodes[0] = int'(q.start_node);
                        nodes[1] = int'(q.end_node);
                        sat = 0;
                        for (int bi = 0; bi < 2; bi++)
                            for (int bj = 0; bj < 2; bj++)
                                for (int i = 0; i < 2; i++)
                                    for (int j = 0; j < 2; j++)
                                        if (add_entry(nodes[bi]*2 + i, nodes[bj]*2 + j,
                                                      el[bi*2 + i][bj*2 + j]))
                                            sat = 1;
                        if (sat) begin
                            rsp.status = tsa_pkg::ST_SAT;
                            n_sat++;
                        end
                    end
                end
                default: ;
            endcase
            expected_q.push_back(rsp);
        endfunction

        function void check_response(tsa_pkg::tsa_rsp_t got);
            tsa_pkg::tsa_rsp_t exp;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected response: value=%0d status=%0d",
                             got.entry_value, got.status);
                return;
            end
            exp = expected_q.pop_front();
            n_checked++;
            if (got.entry_value !== exp.entry_value || got.status !== exp.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("response %0d: expected value=%0d status=%0d, %s%0d status=%0d",
                             n_checked, exp.entry_value, exp.status, "got value=",
                             got.entry_value, got.status);
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              req_valid;
    logic              req_stall;
    tsa_pkg::tsa_req_t req;
    logic              rsp_valid;
    logic              rsp_stall;
    tsa_pkg::tsa_rsp_t rsp;

    stiffness_scoreboard sb;
    bit  calm;          // no idling on either side
    bit  hold_off_go;   // receiver long stall request
    int  cycles;

    truss_stiffness_assembly dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("truss_stiffness_assembly: mismatch");
            $finish;
        end
    end

    // response side: random stalls plus one long hold-off
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                sb.check_response(rsp);
            if (hold_off_go) begin
                hold_off_go = 0;
                hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                rsp_stall <= 1'b1;
            end else
                rsp_stall <= !calm && ($urandom_range(99) < 17);
        end
    end

    task automatic send(tsa_pkg::tsa_req_t item);
        while (!calm && $urandom_range(99) < 17) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= item;
        do @(posedge clk); while (req_stall);
        sb.note_request(item);
    endtask

    function automatic tsa_pkg::tsa_req_t blank(logic [1:0] kind);
        tsa_pkg::tsa_req_t r;
        r = '0;
        r.req_type = kind;
        return r;
    endfunction

    function automatic tsa_pkg::tsa_req_t spring(int sn, int en, int sx, int sy, int ex,
                                                 int ey, int k, bit rigid);
        tsa_pkg::tsa_req_t r;
        r = blank(tsa_pkg::REQ_ADD);
        r.start_node = 6'(sn);
        r.end_node = 6'(en);
        r.start_x = 16'(sx);
        r.start_y = 16'(sy);
        r.end_x = 16'(ex);
        r.end_y = 16'(ey);
        r.spring_stiffness = 24'(k);
        r.rigid_flag = rigid;
        return r;
    endfunction

    function automatic tsa_pkg::tsa_req_t read_at(int row, int col);
        tsa_pkg::tsa_req_t r;
        r = blank(tsa_pkg::REQ_READ);
        r.read_row = 7'(row);
        r.read_col = 7'(col);
        return r;
    endfunction

    function automatic logic [15:0] near_coord();
        return 16'(int'($urandom_range(2047)) - 1024);
    endfunction

    // random request: mostly springs among a few nodes and reads that hit them
    function automatic tsa_pkg::tsa_req_t random_request();
        tsa_pkg::tsa_req_t r;
        logic [127:0] raw;
        int pick;
        raw = {$urandom, $urandom, $urandom, $urandom};
        r = raw[REQ_W-1:0];
        pick = int'($urandom_range(999));
        if (pick < 6)
            r.req_type = tsa_pkg::REQ_CLEAR;
        else if (pick < 25)
            r.req_type = REQ_UNUSED;
        else if (pick < 380) begin
            r.req_type = tsa_pkg::REQ_READ;
            if ($urandom_range(9) < 8) begin
                r.read_row = 7'($urandom_range(15));
                r.read_col = 7'($urandom_range(15));
            end
        end else begin
            r.req_type = tsa_pkg::REQ_ADD;
            if ($urandom_range(9) < 8) begin
                r.start_node = 6'($urandom_range(7));
                r.end_node = 6'($urandom_range(7));
            end
            if ($urandom_range(1) != 0) begin
                r.start_x = near_coord();
                r.start_y = near_coord();
                r.end_x = near_coord();
                r.end_y = near_coord();
            end
            if ($urandom_range(19) == 0) begin
                r.end_x = r.start_x;
                r.end_y = r.start_y;
            end
            r.rigid_flag = ($urandom_range(9) == 0);
        end
        return r;
    endfunction

    initial
    begin
        sb = new();
        calm = 0;
        hold_off_go = 0;
        cycles = 0;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send(spring(0, 1, 0, 0, 256, 0, 256, 0));
        send(read_at(0, 0));
        send(read_at(0, 2));
        send(spring(1, 2, 256, 0, 512, 256, 24'hFFFFFF, 0));
        send(read_at(2, 3));
        send(read_at(3, 3));
        send(spring(2, 3, 100, 100, 300, 300, 1000, 1));
        send(spring(3, 4, 5, 5, 5, 5, 500, 0));
        send(spring(3, 4, -7, 9, -7, 9, 500, 1));
        send(spring(62, 63, -32768, -32768, 32767, 32767, 24'hFFFFFF, 0));
        send(spring(63, 62, 32767, -32768, -32768, 32767, 24'hFFFFFF, 0));
        send(read_at(127, 127));
        send(read_at(124, 126));
        send(spring(5, 5, 0, 0, -1, 1, 24'hFFFFFF, 0));
        send(read_at(10, 11));
        send(spring(6, 7, 0, 0, 1, 0, 0, 0));
        send(blank(REQ_UNUSED));
        send(read_at(1, 0));
        send(blank(tsa_pkg::REQ_CLEAR));
        send(read_at(0, 0));
        send(read_at(127, 127));

        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 200 && n < 260);
            if (n == 100)
                hold_off_go = 1;
            send(random_request());
        end
        calm = 0;
        req_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        $display("covered %0d spring adds (%0d zero length, %0d saturating), %0d reads",
                 sb.n_add, sb.n_zero_len, sb.n_sat, sb.n_read);
        $display("and %0d clears; %0d responses checked, %0d mismatches",
                 sb.n_clear, sb.n_checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("truss_stiffness_assembly: match");
        else
            $display("truss_stiffness_assembly: mismatch");
        $finish;
    end

endmodule

`default_nettype wire
